>>> design/sfp_pkg.sv
// shared codes and characters of the serial frame parser
package sfp_pkg;

	// frame characters
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	// parse phases, one-hot
	typedef enum logic [6:0] {
		PH_START   = 7'b0000001,
		PH_HDR1    = 7'b0000010,
		PH_HDR2    = 7'b0000100,
		PH_HDR3    = 7'b0001000,
		PH_LENGTH  = 7'b0010000,
		PH_TOKEN   = 7'b0100000,
		PH_PAYLOAD = 7'b1000000
	} phase_t;

	// checksum seed of the fixed characters, length byte still to be mixed in
	localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

endpackage

>>> design/serial_frame_parser_xor_check.sv
// serial frame parser: header, length, token, streamed payload, xor checksum
//
//  channel | signals                                      | request
//  --------+----------------------------------------------+----------------------------
//  rx      | rx_valid rx_ready rx_byte                    | one received byte
//  res     | res_valid res_ready out_kind out_index       | payload byte or frame
//          | out_byte frame_length                        | check result
//
// One byte per cycle unless a byte with a result finds the result slot full:
// a byte lands in the input register, then the phase logic and an xor update
// the parser and load the result register. Reset clears the parser to the
// start phase with no request pending. A stalled result holds only bytes that
// produce a result; bytes without one keep flowing while the result waits.
module serial_frame_parser_xor_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_ready,
	input  logic [7:0]          rx_byte,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [1:0]          out_kind,
	output logic [6:0]          out_index,
	output logic [7:0]          out_byte,
	output logic [7:0]          frame_length
);
	import sfp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t     phase_q;
	logic [7:0] remain_q;
	logic [6:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] len_q;

	// result register
	logic       res_valid_q;
	kind_t      kind_q;
	logic [6:0] index_q;
	logic [7:0] obyte_q;
	logic [7:0] flen_q;

	// next values
	phase_t     phase_d;
	logic [7:0] remain_d;
	logic [6:0] pos_d;
	logic [7:0] xor_d;
	logic [7:0] len_d;
	logic       produce;
	kind_t      kind_d;
	logic [6:0] index_d;
	logic       in_payload_range;
	logic       advance;

	// remaining count between 2 and 127 as two's complement
	assign in_payload_range = !remain_q[7] && (remain_q[6:1] != 6'd0);

	// phase logic for the byte in the input register
	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		pos_d    = pos_q;
		xor_d    = xor_q;
		len_d    = len_q;
		produce  = 1'b0;
		kind_d   = KIND_PAYLOAD;
		index_d  = 7'd0;
		unique case (phase_q)
			PH_HDR1: begin
				if (byte_s1 == CH_N) begin
					phase_d = PH_HDR2;
				end else if (byte_s1 == CH_U) begin
					phase_d = PH_HDR1;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_HDR2: begin
				if (byte_s1 == CH_E) begin
					phase_d = PH_HDR3;
				end else if (byte_s1 == CH_U) begin
					phase_d = PH_HDR1;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_HDR3: begin
				if (byte_s1 == CH_R) begin
					phase_d = PH_LENGTH;
				end else if (byte_s1 == CH_U) begin
					phase_d = PH_HDR1;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_LENGTH: begin
				len_d    = byte_s1;
				remain_d = byte_s1;
				phase_d  = PH_TOKEN;
			end
			PH_TOKEN: begin
				if (byte_s1 == CH_COLON) begin
					phase_d = PH_PAYLOAD;
					xor_d   = HDR_XOR ^ len_q;
					pos_d   = 7'd1;
				end else if (byte_s1 == CH_U) begin
					phase_d = PH_HDR1;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_START;
				end
			end
			PH_PAYLOAD: begin
				produce  = 1'b1;
				remain_d = remain_q - 8'd1;
				if (in_payload_range) begin
					kind_d  = KIND_PAYLOAD;
					index_d = pos_q;
					xor_d   = xor_q ^ byte_s1;
					pos_d   = pos_q + 7'd1;
				end else begin
					kind_d = (xor_q == byte_s1) ? KIND_GOOD : KIND_BAD;
					// checksum byte also examined as a new start
					if (byte_s1 == CH_U) begin
						phase_d = PH_HDR1;
						xor_d   = 8'd0;
					end else begin
						phase_d = PH_START;
					end
				end
			end
			default: begin
				if (byte_s1 == CH_U) begin
					phase_d = PH_HDR1;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_START;
				end
			end
		endcase
	end

	// handshake: a byte moves on unless its result finds the slot full
	assign advance  = valid_s1 && (!produce || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			remain_q <= 8'd0;
			pos_q    <= 7'd0;
			xor_q    <= 8'd0;
			len_q    <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
			xor_q    <= xor_d;
			len_q    <= len_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produce) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			kind_q  <= kind_d;
			index_q <= index_d;
			obyte_q <= byte_s1;
			flen_q  <= len_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_kind     = kind_q;
	assign out_index    = index_q;
	assign out_byte     = obyte_q;
	assign frame_length = flen_q;

endmodule

>>> design/sfp_checker.sv
// port checker for the serial frame parser, bound to the top level
module sfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic [7:0] rx_byte,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] out_kind,
	input logic [6:0] out_index,
	input logic [7:0] out_byte,
	input logic [7:0] frame_length
);
	import sfp_pkg::*;

	// a waiting request holds its byte
	a_rx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && !rx_ready |=> rx_valid && $stable(rx_byte))
		else $error("waiting request changed");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_kind)
			&& $stable(out_index) && $stable(out_byte) && $stable(frame_length))
		else $error("stalled result changed");

	// only the three defined kinds appear
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_kind == KIND_PAYLOAD || out_kind == KIND_GOOD
			|| out_kind == KIND_BAD)
		else $error("undefined result kind");

	// payload requests carry a position, frame ends carry none
	a_index_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((out_kind == KIND_PAYLOAD) == (out_index != 7'd0)))
		else $error("index does not match kind");

	// payload only within frames of positive length above one
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind == KIND_PAYLOAD |->
			!frame_length[7] && frame_length[6:1] != 6'd0
			&& {1'b0, out_index} < frame_length)
		else $error("payload outside frame length");

endmodule

bind serial_frame_parser_xor_check sfp_checker u_sfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx_valid),
	.rx_ready     (rx_ready),
	.rx_byte      (rx_byte),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.out_kind     (out_kind),
	.out_index    (out_index),
	.out_byte     (out_byte),
	.frame_length (frame_length)
);

>>> dv/tb_serial_frame_parser_xor_check.sv
`timescale 1ns / 1ps
// testbench for the serial frame parser: directed and random byte streams checked against a parser mirror
module tb_serial_frame_parser_xor_check;
	import sfp_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int FRAMED_ITEMS = 770;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] index;
		logic [7:0] data;
		logic [7:0] length;
	} frame_result_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [1:0] out_kind;
	logic [6:0] out_index;
	logic [7:0] out_byte;
	logic [7:0] frame_length;

	serial_frame_parser_xor_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_kind     (out_kind),
		.out_index    (out_index),
		.out_byte     (out_byte),
		.frame_length (frame_length)
	);

	always #5 clk = ~clk;

	// mirror of the parser state
	phase_t        parse_phase      = PH_START;
	logic [7:0]    remaining_count  = 8'h00;
	logic [6:0]    payload_position = 7'd0;
	logic [7:0]    running_xor      = 8'h00;
	logic [7:0]    length_seen      = 8'h00;
	frame_result_t pending_results[$];

	int err_count    = 0;
	int framed_count = 0;
	int burst_left   = 0;
	bit sender_gaps  = 1'b1;

	// a byte that breaks a frame may itself open the next one
	function automatic phase_t restart_phase(input logic [7:0] b);
		return (b == CH_U) ? PH_HDR1 : PH_START;
	endfunction

	// advance the mirror by one accepted byte, queue any result it causes
	task automatic parse_rx_byte(input logic [7:0] b);
		frame_result_t r;
		case (parse_phase)
			PH_HDR1: parse_phase = (b == CH_N) ? PH_HDR2 : restart_phase(b);
			PH_HDR2: parse_phase = (b == CH_E) ? PH_HDR3 : restart_phase(b);
			PH_HDR3: parse_phase = (b == CH_R) ? PH_LENGTH : restart_phase(b);
			PH_LENGTH: begin
				length_seen     = b;
				remaining_count = b;
				parse_phase     = PH_TOKEN;
			end
			PH_TOKEN: begin
				if (b == CH_COLON) begin
					parse_phase      = PH_PAYLOAD;
					running_xor      = HDR_XOR ^ length_seen;
					payload_position = 7'd1;
				end else begin
					parse_phase = restart_phase(b);
				end
			end
			PH_PAYLOAD: begin
				r.data   = b;
				r.length = length_seen;
				if (remaining_count >= 8'd2 && remaining_count <= 8'd127) begin
					r.kind           = KIND_PAYLOAD;
					r.index          = payload_position;
					running_xor      = running_xor ^ b;
					payload_position = payload_position + 7'd1;
				end else begin
					r.kind      = (running_xor == b) ? KIND_GOOD : KIND_BAD;
					r.index     = 7'd0;
					parse_phase = restart_phase(b);
				end
				remaining_count = remaining_count - 8'd1;
				pending_results.push_back(r);
			end
			default: parse_phase = restart_phase(b);
		endcase
	endtask

	// send one byte, with bursts and gaps on the request side
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (sender_gaps && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		parse_rx_byte(b);
	endtask

	// hold off requests until every queued result has come out
	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// whole frame with random payload, checksum right or spoiled
	task automatic send_frame(input logic [7:0] len, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		int         n;
		sum = HDR_XOR ^ len;
		n   = (len >= 8'd2 && len <= 8'd127) ? int'(len) - 1 : 0;
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_E);
		send_byte(CH_R);
		send_byte(len);
		send_byte(CH_COLON);
		repeat (n) begin
			b   = 8'($urandom);
			sum = sum ^ b;
			send_byte(b);
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
		framed_count += n + 7;
	endtask

	// lengths: mostly short, often the edges, now and then long
	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 5))
				0: return 8'd0;
				1: return 8'd1;
				2: return 8'd2;
				3: return 8'd127;
				4: return 8'd128;
				default: return 8'd255;
			endcase
		end
		if (r < 80)
			return 8'($urandom_range(2, 12));
		if (r < 93)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(13, 90));
	endfunction

	task automatic test_payload_frame();
		send_frame(8'd2, 1'b0);
	endtask

	// header, token and checksum bytes that restart on 'U'
	task automatic test_restarts();
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_E);
		send_byte(CH_R);
		send_byte(8'h01);
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_E);
		send_byte(CH_R);
		send_byte(8'h80);
		send_byte(CH_COLON);
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_E);
		send_byte(CH_R);
		send_byte(8'h01);
		send_byte(CH_COLON);
		send_byte(HDR_XOR ^ 8'h01);
	endtask

	task automatic test_longest_frame();
		send_frame(8'd127, 1'b0);
	endtask

	task automatic test_drain_pause();
		send_frame(pick_length(), 1'b0);
		wait_drained();
		send_frame(pick_length(), 1'b1);
	endtask

	// mostly well-formed frames, some broken ones and line noise
	task automatic test_random_traffic();
		int         sel;
		int         k;
		logic [7:0] prefix [0:4];
		framed_count = 0;
		while (framed_count < FRAMED_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				sender_gaps = ~sender_gaps;
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				send_frame(pick_length(), $urandom_range(0, 3) == 0);
			end else if (sel < 88) begin
				prefix = '{CH_U, CH_N, CH_E, CH_R, pick_length()};
				k = $urandom_range(1, 5);
				for (int i = 0; i < k; i++)
					send_byte(prefix[i]);
				send_byte(8'($urandom));
				framed_count += k + 1;
			end else begin
				k = $urandom_range(1, 6);
				repeat (k) send_byte(8'($urandom));
				framed_count += k;
			end
		end
		sender_gaps = 1'b1;
	endtask

	// receiver stall pattern, reloaded after a random run length
	logic [7:0] stall_pattern = 8'hFF;
	int         pattern_left  = 0;

	always @(posedge clk) begin
		if (pattern_left == 0) begin
			pattern_left  <= $urandom_range(64, 300);
			stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		end else begin
			pattern_left  <= pattern_left - 1;
			stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
		end
		res_ready <= stall_pattern[0];
	end

	// compare each result with the oldest queued one
	frame_result_t oldest;

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d index %0d byte %h length %h",
					out_kind, out_index, out_byte, frame_length);
				err_count++;
			end else begin
				oldest = pending_results.pop_front();
				if (out_kind !== oldest.kind) begin
					$error("out_kind expected %0d actual %0d", oldest.kind, out_kind);
					err_count++;
				end
				if (out_index !== oldest.index) begin
					$error("out_index expected %0d actual %0d", oldest.index, out_index);
					err_count++;
				end
				if (out_byte !== oldest.data) begin
					$error("out_byte expected %h actual %h", oldest.data, out_byte);
					err_count++;
				end
				if (frame_length !== oldest.length) begin
					$error("frame_length expected %h actual %h", oldest.length, frame_length);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_payload_frame();
		test_restarts();
		test_drain_pause();
		test_longest_frame();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
